// File: hdl/pbrq_pkg.sv
// shared types and constants of the priority bitmap run queue
package pbrq_pkg;

  // field widths of the channel words
  localparam int TASK_ID_W = 5;
  localparam int PRIO_W    = 6;

  // operation codes of an input word
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_SETPRIO = 2'd2,
    OP_PICK    = 2'd3
  } pbrq_op_t;

  // status codes of a result word
  localparam logic ST_DONE      = 1'b0;
  localparam logic ST_NO_CHANGE = 1'b1;

endpackage

// File: hdl/pbrq_if.sv
// valid/ready channel interfaces for command and result words
interface pbrq_in_if;
  logic                               valid;
  logic                               ready;
  pbrq_pkg::pbrq_op_t                 operation;
  logic [pbrq_pkg::TASK_ID_W-1:0]     task_id;
  logic [pbrq_pkg::PRIO_W-1:0]        new_priority;
  logic                               deactivate_current;

  modport source (output valid, operation, task_id, new_priority, deactivate_current,
                  input ready);
  modport sink   (input valid, operation, task_id, new_priority, deactivate_current,
                  output ready);
endinterface

interface pbrq_out_if;
  logic                               valid;
  logic                               ready;
  logic                               status;
  logic [pbrq_pkg::TASK_ID_W-1:0]     next_task;
  logic                               next_is_idle;
  logic                               resched_req;
  logic                               queue_empty;

  modport source (output valid, status, next_task, next_is_idle, resched_req, queue_empty,
                  input ready);
  modport sink   (input valid, status, next_task, next_is_idle, resched_req, queue_empty,
                  output ready);
endinterface

// File: hdl/pbrq_find_first.sv
// two-stage registered search for the lowest set bit of the level bitmap
module pbrq_find_first #(
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic [WIDTH-1:0]         bits,
  output logic                     found,
  output logic [$clog2(WIDTH)-1:0] index
);

  localparam int IW    = $clog2(WIDTH);
  localparam int GROUP = 16;
  localparam int GW    = $clog2(GROUP);
  localparam int NG    = (WIDTH + GROUP - 1) / GROUP;
  localparam int PADW  = NG * GROUP;

  logic [PADW-1:0] padded;
  logic [NG-1:0]   any_c;
  logic [NG-1:0]   any_r;
  logic [GW-1:0]   sub_c [NG];
  logic [GW-1:0]   sub_r [NG];
  logic            hit_c;
  logic [IW-1:0]   idx_c;
  logic            found_r;
  logic [IW-1:0]   index_r;

  assign padded = PADW'(bits);

  // stage one: per group, any bit set and lowest set position
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      any_c[g] = |padded[g*GROUP +: GROUP];
      sub_c[g] = '0;
      for (int i = GROUP - 1; i >= 0; i--) begin
        if (padded[g*GROUP + i]) begin
          sub_c[g] = GW'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    any_r <= any_c;
    sub_r <= sub_c;
  end

  // stage two: lowest group that holds a set bit
  always_comb begin
    hit_c = |any_r;
    idx_c = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (any_r[g]) begin
        idx_c = IW'(g * GROUP + int'(sub_r[g]));
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r <= hit_c;
    index_r <= idx_c;
  end

  assign found = found_r;
  assign index = index_r;

endmodule

// File: hdl/priority_bitmap_run_queue_unit.sv
// top level of the priority bitmap run queue
//
// Run queue for a priority scheduler: one FIFO list of task numbers per
// priority level (level 0 most urgent) kept as a doubly linked list in a
// task memory (priority, next, prev) and a level memory (head, tail), plus
// one non-empty bit per level. Each command word gives one result word.
// Commands are handled one at a time; a new word is taken only when the
// sequencer is idle, while the previous result may still sit in the output
// register. From acceptance to result a word's time is set by the number
// of dependent accesses to the single-port task and level memories; a
// pick's lowest-level search runs through a registered two-stage encoder,
// and a task number beyond the task count goes straight to the result.
// A result that finds the output register still full waits in the
// sequencer until it drains. Per-task priorities read as the last, least
// urgent level until first written; no clearing pass is needed after
// reset.
module priority_bitmap_run_queue_unit #(
  parameter int TASK_COUNT      = 32,
  parameter int PRIORITY_LEVELS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  pbrq_in_if.sink           in_chan,
  pbrq_out_if.source        out_chan
);

  localparam int TW  = $clog2(TASK_COUNT);
  localparam int PW  = $clog2(PRIORITY_LEVELS);
  localparam int CW  = $clog2(TASK_COUNT + 1);
  localparam int IDW = pbrq_pkg::TASK_ID_W;

  typedef logic [TW-1:0] tid_t;
  typedef logic [PW-1:0] lvl_t;
  typedef logic [PW:0]   rprio_t;

  typedef struct packed {
    lvl_t prio;
    tid_t next;
    tid_t prev;
  } task_ent_t;

  typedef struct packed {
    tid_t head;
    tid_t tail;
  } lvl_ent_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DEQ_RD,
    S_DEQ_LINK,
    S_DEQ_FIX,
    S_SP_RD,
    S_SP_CMP,
    S_SP_WR,
    S_ENQ_RD,
    S_ENQ_LVL,
    S_ENQ_TAIL,
    S_ENQ_SELF,
    S_FIND0,
    S_FIND1,
    S_FIND2,
    S_PICK_HEAD,
    S_PICK_PRIO,
    S_FIN
  } state_t;

  // sequencer and command registers
  state_t             state_r;
  pbrq_pkg::pbrq_op_t op_r;
  tid_t               cur_r;
  lvl_t               np_r;
  lvl_t               lv_r;
  tid_t               nxt_r;
  tid_t               prv_r;
  logic               was_r;
  logic               status_r;
  tid_t               next_r;
  logic               idle_r;

  // run queue state held in flops
  logic [TASK_COUNT-1:0]      queued_r;
  logic [TASK_COUNT-1:0]      prio_vld_r;
  logic [PRIORITY_LEVELS-1:0] nonempty_r;
  logic [CW-1:0]              cnt_r;
  tid_t                       run_task_r;
  logic                       run_idle_r;
  rprio_t                     run_prio_r;
  logic                       resched_r;

  // result register
  logic           out_valid_r;
  logic           out_status_r;
  logic [IDW-1:0] out_next_r;
  logic           out_idle_r;
  logic           out_resched_r;
  logic           out_empty_r;

  // memories and their ports
  task_ent_t task_mem [TASK_COUNT];
  lvl_ent_t  lvl_mem  [PRIORITY_LEVELS];
  task_ent_t task_q_r;
  logic      prio_ok_r;
  lvl_ent_t  lvl_q_r;

  logic      tr_en;
  tid_t      tr_addr;
  logic      tw_prio;
  logic      tw_next;
  logic      tw_prev;
  tid_t      tw_addr;
  task_ent_t tw_ent;
  logic      lr_en;
  lvl_t      lr_addr;
  logic      lw_head;
  logic      lw_tail;
  lvl_t      lw_addr;
  lvl_ent_t  lw_ent;

  // decoded values
  logic   in_fire;
  logic   t_ok;
  lvl_t   np_sat;
  lvl_t   tq_prio;
  logic   is_head;
  logic   is_tail;
  state_t deq_ret;
  logic   out_free;
  logic   ff_found;
  lvl_t   ff_index;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign t_ok     = int'(in_chan.task_id) < TASK_COUNT;
  assign np_sat   = (int'(in_chan.new_priority) >= PRIORITY_LEVELS) ?
                    lvl_t'(PRIORITY_LEVELS - 1) : lvl_t'(in_chan.new_priority);
  assign tq_prio  = prio_ok_r ? task_q_r.prio : lvl_t'(PRIORITY_LEVELS - 1);
  assign is_head  = task_q_r.prev == cur_r;
  assign is_tail  = task_q_r.next == cur_r;
  assign out_free = !out_valid_r || out_chan.ready;

  // where a dequeue returns to
  always_comb begin
    unique case (op_r)
      pbrq_pkg::OP_INSERT,
      pbrq_pkg::OP_REMOVE:  deq_ret = S_FIN;
      pbrq_pkg::OP_SETPRIO: deq_ret = S_SP_WR;
      pbrq_pkg::OP_PICK:    deq_ret = S_FIND0;
    endcase
  end

  // lowest non-empty level
  pbrq_find_first #(
    .WIDTH (PRIORITY_LEVELS)
  ) u_find (
    .clk   (clk),
    .bits  (nonempty_r),
    .found (ff_found),
    .index (ff_index)
  );

  // memory read and write controls per sequencer step
  always_comb begin
    tr_en   = 1'b0;
    tr_addr = cur_r;
    tw_prio = 1'b0;
    tw_next = 1'b0;
    tw_prev = 1'b0;
    tw_addr = cur_r;
    tw_ent  = '0;
    lr_en   = 1'b0;
    lr_addr = lv_r;
    lw_head = 1'b0;
    lw_tail = 1'b0;
    lw_addr = lv_r;
    lw_ent  = '0;
    unique case (state_r)
      S_DEQ_RD: begin
        tr_en = queued_r[cur_r];
      end
      S_DEQ_LINK: begin
        lw_addr = tq_prio;
        if (is_head && !is_tail) begin
          lw_head     = 1'b1;
          lw_ent.head = task_q_r.next;
          tw_prev     = 1'b1;
          tw_addr     = task_q_r.next;
          tw_ent.prev = task_q_r.next;
        end else if (is_tail && !is_head) begin
          lw_tail     = 1'b1;
          lw_ent.tail = task_q_r.prev;
          tw_next     = 1'b1;
          tw_addr     = task_q_r.prev;
          tw_ent.next = task_q_r.prev;
        end else if (!is_head && !is_tail) begin
          tw_next     = 1'b1;
          tw_addr     = task_q_r.prev;
          tw_ent.next = task_q_r.next;
        end
      end
      S_DEQ_FIX: begin
        tw_prev     = 1'b1;
        tw_addr     = nxt_r;
        tw_ent.prev = prv_r;
      end
      S_SP_RD: begin
        tr_en = 1'b1;
      end
      S_SP_WR: begin
        tw_prio     = 1'b1;
        tw_ent.prio = np_r;
      end
      S_ENQ_RD: begin
        tr_en = !queued_r[cur_r];
      end
      S_ENQ_LVL: begin
        lr_addr = tq_prio;
        lw_addr = tq_prio;
        if (nonempty_r[tq_prio]) begin
          lr_en = 1'b1;
        end else begin
          lw_head     = 1'b1;
          lw_tail     = 1'b1;
          lw_ent.head = cur_r;
          lw_ent.tail = cur_r;
          tw_next     = 1'b1;
          tw_prev     = 1'b1;
          tw_ent.next = cur_r;
          tw_ent.prev = cur_r;
        end
      end
      S_ENQ_TAIL: begin
        tw_next     = 1'b1;
        tw_addr     = lvl_q_r.tail;
        tw_ent.next = cur_r;
        lw_tail     = 1'b1;
        lw_ent.tail = cur_r;
      end
      S_ENQ_SELF: begin
        tw_next     = 1'b1;
        tw_prev     = 1'b1;
        tw_ent.next = cur_r;
        tw_ent.prev = prv_r;
      end
      S_FIND2: begin
        lr_en   = ff_found;
        lr_addr = ff_index;
      end
      S_PICK_HEAD: begin
        tr_en   = 1'b1;
        tr_addr = lvl_q_r.head;
      end
      S_IDLE, S_SP_CMP, S_FIND0, S_FIND1, S_PICK_PRIO, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // task memory: priority, next and prev with per-field write enables
  always_ff @(posedge clk) begin
    if (tw_prio) begin
      task_mem[tw_addr].prio <= tw_ent.prio;
    end
    if (tw_next) begin
      task_mem[tw_addr].next <= tw_ent.next;
    end
    if (tw_prev) begin
      task_mem[tw_addr].prev <= tw_ent.prev;
    end
    if (tr_en) begin
      task_q_r  <= task_mem[tr_addr];
      prio_ok_r <= prio_vld_r[tr_addr];
    end
  end

  // level memory: head and tail with per-field write enables
  always_ff @(posedge clk) begin
    if (lw_head) begin
      lvl_mem[lw_addr].head <= lw_ent.head;
    end
    if (lw_tail) begin
      lvl_mem[lw_addr].tail <= lw_ent.tail;
    end
    if (lr_en) begin
      lvl_q_r <= lvl_mem[lr_addr];
    end
  end

  // sequencer, queue bookkeeping and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      op_r          <= pbrq_pkg::OP_INSERT;
      queued_r      <= '0;
      prio_vld_r    <= '0;
      nonempty_r    <= '0;
      cnt_r         <= '0;
      run_task_r    <= '0;
      run_idle_r    <= 1'b1;
      run_prio_r    <= rprio_t'(PRIORITY_LEVELS);
      resched_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r   <= in_chan.operation;
            np_r   <= np_sat;
            next_r <= '0;
            idle_r <= 1'b0;
            if (in_chan.operation == pbrq_pkg::OP_PICK) begin
              status_r <= pbrq_pkg::ST_DONE;
              if (in_chan.deactivate_current && !run_idle_r) begin
                cur_r   <= run_task_r;
                state_r <= S_DEQ_RD;
              end else begin
                cur_r   <= tid_t'(in_chan.task_id);
                state_r <= S_FIND0;
              end
            end else if (!t_ok) begin
              cur_r    <= tid_t'(in_chan.task_id);
              status_r <= pbrq_pkg::ST_NO_CHANGE;
              state_r  <= S_FIN;
            end else begin
              cur_r <= tid_t'(in_chan.task_id);
              unique case (in_chan.operation)
                pbrq_pkg::OP_INSERT:  state_r <= S_ENQ_RD;
                pbrq_pkg::OP_REMOVE:  state_r <= S_DEQ_RD;
                pbrq_pkg::OP_SETPRIO: state_r <= S_SP_RD;
                pbrq_pkg::OP_PICK:    state_r <= S_FIND0;
              endcase
            end
          end
        end
        // unlink: read the entry, then patch neighbors
        S_DEQ_RD: begin
          if (op_r == pbrq_pkg::OP_REMOVE) begin
            status_r <= queued_r[cur_r] ? pbrq_pkg::ST_DONE : pbrq_pkg::ST_NO_CHANGE;
          end
          state_r <= queued_r[cur_r] ? S_DEQ_LINK : deq_ret;
        end
        S_DEQ_LINK: begin
          nxt_r           <= task_q_r.next;
          prv_r           <= task_q_r.prev;
          queued_r[cur_r] <= 1'b0;
          cnt_r           <= cnt_r - CW'(1);
          if (is_head && is_tail) begin
            nonempty_r[tq_prio] <= 1'b0;
          end
          state_r <= (!is_head && !is_tail) ? S_DEQ_FIX : deq_ret;
        end
        S_DEQ_FIX: begin
          state_r <= deq_ret;
        end
        // priority change
        S_SP_RD: begin
          state_r <= S_SP_CMP;
        end
        S_SP_CMP: begin
          if (np_r == tq_prio) begin
            status_r <= pbrq_pkg::ST_NO_CHANGE;
            state_r  <= S_FIN;
          end else begin
            status_r <= pbrq_pkg::ST_DONE;
            was_r    <= queued_r[cur_r];
            state_r  <= queued_r[cur_r] ? S_DEQ_RD : S_SP_WR;
          end
        end
        S_SP_WR: begin
          prio_vld_r[cur_r] <= 1'b1;
          if (!run_idle_r && run_task_r == cur_r) begin
            run_prio_r <= {1'b0, np_r};
          end
          state_r <= was_r ? S_ENQ_RD : S_FIN;
        end
        // link at the tail of the task's level
        S_ENQ_RD: begin
          if (op_r == pbrq_pkg::OP_INSERT) begin
            status_r <= queued_r[cur_r] ? pbrq_pkg::ST_NO_CHANGE : pbrq_pkg::ST_DONE;
          end
          state_r <= queued_r[cur_r] ? S_FIN : S_ENQ_LVL;
        end
        S_ENQ_LVL: begin
          lv_r <= tq_prio;
          if (nonempty_r[tq_prio]) begin
            state_r <= S_ENQ_TAIL;
          end else begin
            nonempty_r[tq_prio] <= 1'b1;
            queued_r[cur_r]     <= 1'b1;
            cnt_r               <= cnt_r + CW'(1);
            if ({1'b0, tq_prio} < run_prio_r) begin
              resched_r <= 1'b1;
            end
            state_r <= S_FIN;
          end
        end
        S_ENQ_TAIL: begin
          prv_r   <= lvl_q_r.tail;
          state_r <= S_ENQ_SELF;
        end
        S_ENQ_SELF: begin
          queued_r[cur_r] <= 1'b1;
          cnt_r           <= cnt_r + CW'(1);
          if ({1'b0, lv_r} < run_prio_r) begin
            resched_r <= 1'b1;
          end
          state_r <= S_FIN;
        end
        // pick: wait for the encoder, then read head and its priority
        S_FIND0: begin
          state_r <= S_FIND1;
        end
        S_FIND1: begin
          state_r <= S_FIND2;
        end
        S_FIND2: begin
          if (ff_found) begin
            state_r <= S_PICK_HEAD;
          end else begin
            idle_r     <= 1'b1;
            run_task_r <= '0;
            run_idle_r <= 1'b1;
            run_prio_r <= rprio_t'(PRIORITY_LEVELS);
            resched_r  <= 1'b0;
            state_r    <= S_FIN;
          end
        end
        S_PICK_HEAD: begin
          next_r  <= lvl_q_r.head;
          state_r <= S_PICK_PRIO;
        end
        S_PICK_PRIO: begin
          run_task_r <= next_r;
          run_idle_r <= 1'b0;
          run_prio_r <= {1'b0, tq_prio};
          resched_r  <= 1'b0;
          state_r    <= S_FIN;
        end
        // hand the result word to the output register
        S_FIN: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= status_r;
            out_next_r    <= IDW'(next_r);
            out_idle_r    <= idle_r;
            out_resched_r <= resched_r;
            out_empty_r   <= cnt_r == '0;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready         = state_r == S_IDLE;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.next_task    = out_next_r;
  assign out_chan.next_is_idle = out_idle_r;
  assign out_chan.resched_req  = out_resched_r;
  assign out_chan.queue_empty  = out_empty_r;

`ifndef NO_ASSERTIONS
  // task count and level bitmap agree on emptiness between commands
  a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((cnt_r == '0) == (nonempty_r == '0)))
    else $error("task count and level bitmap disagree");

  // unlinking only ever touches a queued task
  a_unlink_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEQ_LINK) |-> queued_r[cur_r])
    else $error("unlink of a task that is not queued");

  // a pick always leaves the reschedule flag clear
  a_pick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && op_r == pbrq_pkg::OP_PICK) |-> !resched_r)
    else $error("reschedule flag still set after pick");

  // a result word appears only out of the finishing step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result word loaded outside the finishing step");
`endif

endmodule

// File: test/priority_bitmap_run_queue_unit_tb.sv
// self-checking testbench of the priority bitmap run queue unit
`timescale 1ns / 1ps

module priority_bitmap_run_queue_unit_tb;

  localparam int TID_W        = pbrq_pkg::TASK_ID_W;
  localparam int PRI_W        = pbrq_pkg::PRIO_W;
  localparam int NUM_TASKS    = 32;
  localparam int NUM_LEVELS   = 64;
  localparam logic [PRI_W:0] IDLE_LEVEL = (PRI_W + 1)'(NUM_LEVELS);
  localparam int RANDOM_WORDS = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_CYCLES  = 150;
  localparam int HOLD_AT      = 80;

  // one command word and one result word
  typedef struct {
    pbrq_pkg::pbrq_op_t op;
    logic [TID_W-1:0]   tid;
    logic [PRI_W-1:0]   prio;
    logic               deact;
  } sched_cmd_t;

  typedef struct {
    logic             status;
    logic [TID_W-1:0] next_task;
    logic             next_is_idle;
    logic             resched_req;
    logic             queue_empty;
  } sched_result_t;

  typedef struct {
    sched_cmd_t    cmd;
    bit            typed;
    sched_result_t res;
  } directed_row_t;

  logic clk;
  logic rst_n;

  pbrq_in_if  in_chan ();
  pbrq_out_if out_chan ();

  priority_bitmap_run_queue_unit #(
    .TASK_COUNT      (NUM_TASKS),
    .PRIORITY_LEVELS (NUM_LEVELS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run queue shadow state
  logic [PRI_W-1:0]      rq_prio   [NUM_TASKS];
  bit                    rq_queued [NUM_TASKS];
  logic [TID_W-1:0]      rq_next   [NUM_TASKS];
  logic [TID_W-1:0]      rq_prev   [NUM_TASKS];
  logic [TID_W-1:0]      lvl_head  [NUM_LEVELS];
  logic [TID_W-1:0]      lvl_tail  [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] lvl_busy;
  logic [TID_W-1:0]      cur_task;
  bit                    cur_idle;
  logic [PRI_W:0]        cur_prio;
  bit                    resched;

  sched_result_t pending_results[$];
  int errors;
  int words_sent;
  int results_seen;
  int picks_seen;
  int idle_picks;
  int no_change_seen;

  // append a task at the tail of its level
  function automatic bit rq_link(input logic [TID_W-1:0] t);
    logic [PRI_W-1:0] lv;
    lv = rq_prio[t];
    if (rq_queued[t]) return pbrq_pkg::ST_NO_CHANGE;
    if (lvl_busy[lv]) begin
      rq_next[lvl_tail[lv]] = t;
      rq_prev[t] = lvl_tail[lv];
    end else begin
      lvl_head[lv] = t;
      rq_prev[t] = t;
      lvl_busy[lv] = 1'b1;
    end
    rq_next[t] = t;
    lvl_tail[lv] = t;
    rq_queued[t] = 1'b1;
    if ({1'b0, lv} < cur_prio) resched = 1'b1;
    return pbrq_pkg::ST_DONE;
  endfunction

  // unlink a task from its level list
  function automatic bit rq_unlink(input logic [TID_W-1:0] t);
    logic [PRI_W-1:0] lv;
    logic [TID_W-1:0] p;
    logic [TID_W-1:0] n;
    bit               at_head;
    bit               at_tail;
    lv = rq_prio[t];
    if (!rq_queued[t]) return pbrq_pkg::ST_NO_CHANGE;
    at_head = lvl_head[lv] == t;
    at_tail = lvl_tail[lv] == t;
    p = rq_prev[t];
    n = rq_next[t];
    if (at_head && at_tail) begin
      lvl_busy[lv] = 1'b0;
    end else if (at_head) begin
      lvl_head[lv] = n;
      rq_prev[n] = n;
    end else if (at_tail) begin
      lvl_tail[lv] = p;
      rq_next[p] = p;
    end else begin
      rq_next[p] = n;
      rq_prev[n] = p;
    end
    rq_queued[t] = 1'b0;
    return pbrq_pkg::ST_DONE;
  endfunction

  // apply one command to the shadow run queue and give its result word
  // (task ids and priorities cannot leave range at these widths)
  function automatic sched_result_t schedule_step(input sched_cmd_t c);
    sched_result_t r;
    int            sel;
    bit            was_queued;
    r.status       = pbrq_pkg::ST_NO_CHANGE;
    r.next_task    = '0;
    r.next_is_idle = 1'b0;
    if (c.op == pbrq_pkg::OP_PICK) begin
      if (c.deact && !cur_idle) void'(rq_unlink(cur_task));
      sel = -1;
      for (int lv = NUM_LEVELS - 1; lv >= 0; lv--) begin
        if (lvl_busy[lv]) sel = lv;
      end
      if (sel >= 0) begin
        r.next_task = lvl_head[sel];
        cur_task = lvl_head[sel];
        cur_idle = 1'b0;
        cur_prio = {1'b0, rq_prio[lvl_head[sel]]};
      end else begin
        r.next_is_idle = 1'b1;
        cur_task = '0;
        cur_idle = 1'b1;
        cur_prio = IDLE_LEVEL;
      end
      resched = 1'b0;
      r.status = pbrq_pkg::ST_DONE;
    end else if (c.op == pbrq_pkg::OP_INSERT) begin
      r.status = rq_link(c.tid);
    end else if (c.op == pbrq_pkg::OP_REMOVE) begin
      r.status = rq_unlink(c.tid);
    end else if (c.prio != rq_prio[c.tid]) begin
      // priority change moves a queued task to the tail of its new level
      was_queued = rq_queued[c.tid];
      if (was_queued) void'(rq_unlink(c.tid));
      rq_prio[c.tid] = c.prio;
      if (!cur_idle && cur_task == c.tid) cur_prio = {1'b0, c.prio};
      if (was_queued) void'(rq_link(c.tid));
      r.status = pbrq_pkg::ST_DONE;
    end
    r.resched_req = resched;
    r.queue_empty = lvl_busy == '0;
    return r;
  endfunction

  function automatic sched_cmd_t mk_cmd(input pbrq_pkg::pbrq_op_t op, input int tid,
                                        input int prio, input int deact);
    sched_cmd_t c;
    c.op    = op;
    c.tid   = TID_W'(tid);
    c.prio  = PRI_W'(prio);
    c.deact = deact != 0;
    return c;
  endfunction

  function automatic sched_result_t mk_res(input logic st, input int nt, input int idle,
                                           input int rs, input int em);
    sched_result_t r;
    r.status       = st;
    r.next_task    = TID_W'(nt);
    r.next_is_idle = idle != 0;
    r.resched_req  = rs != 0;
    r.queue_empty  = em != 0;
    return r;
  endfunction

  function automatic directed_row_t mk_row(input sched_cmd_t c, input bit typed,
                                           input sched_result_t r);
    directed_row_t d;
    d.cmd   = c;
    d.typed = typed;
    d.res   = r;
    return d;
  endfunction

  // random command, biased to a few tasks and the extreme levels
  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 32) c.op = pbrq_pkg::OP_INSERT;
    else if (r < 52) c.op = pbrq_pkg::OP_REMOVE;
    else if (r < 72) c.op = pbrq_pkg::OP_SETPRIO;
    else c.op = pbrq_pkg::OP_PICK;
    c.tid = TID_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 31));
    if ($urandom_range(0, 2) == 0) c.prio = PRI_W'($urandom_range(0, 63));
    else c.prio = ($urandom_range(0, 1) ? 6'd63 : 6'd0) ^ PRI_W'($urandom_range(0, 3));
    c.deact = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // drive one command word and wait for it to be taken
  task automatic offer_cmd(input sched_cmd_t c, input bit typed, input sched_result_t tres);
    sched_result_t p;
    in_chan.valid              <= 1'b1;
    in_chan.operation          <= c.op;
    in_chan.task_id            <= c.tid;
    in_chan.new_priority       <= c.prio;
    in_chan.deactivate_current <= c.deact;
    do @(posedge clk); while (!in_chan.ready);
    p = schedule_step(c);
    words_sent++;
    if (c.op == pbrq_pkg::OP_PICK) picks_seen++;
    if (p.next_is_idle) idle_picks++;
    if (p.status == pbrq_pkg::ST_NO_CHANGE) no_change_seen++;
    pending_results.push_back(typed ? tres : p);
  endtask

  // sender: bursts of words with random gaps
  int burst_left;

  task automatic send_with_gaps(input sched_cmd_t c, input bit typed,
                                input sched_result_t tres);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    offer_cmd(c, typed, tres);
  endtask

  // stimulus and end of run
  initial begin
    directed_row_t directed[$];
    sched_result_t blank;
    for (int t = 0; t < NUM_TASKS; t++) begin
      rq_prio[t]   = PRI_W'(NUM_LEVELS - 1);
      rq_queued[t] = 1'b0;
    end
    lvl_busy = '0;
    cur_task = '0;
    cur_idle = 1'b1;
    cur_prio = IDLE_LEVEL;
    resched  = 1'b0;
    errors = 0;
    words_sent = 0;
    picks_seen = 0;
    idle_picks = 0;
    no_change_seen = 0;
    burst_left = 0;
    blank = mk_res(pbrq_pkg::ST_DONE, 0, 0, 0, 0);

    rst_n                      <= 1'b0;
    in_chan.valid              <= 1'b0;
    in_chan.operation          <= pbrq_pkg::OP_INSERT;
    in_chan.task_id            <= '0;
    in_chan.new_priority       <= '0;
    in_chan.deactivate_current <= 1'b0;

    // opening rows straight from reset, then list surgery checked by prediction
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_PICK, 0, 0, 0), 1'b1,
                              mk_res(pbrq_pkg::ST_DONE, 0, 1, 0, 1)));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_REMOVE, 5, 0, 0), 1'b1,
                              mk_res(pbrq_pkg::ST_NO_CHANGE, 0, 0, 0, 1)));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_SETPRIO, 5, 63, 0), 1'b1,
                              mk_res(pbrq_pkg::ST_NO_CHANGE, 0, 0, 0, 1)));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_INSERT, 31, 0, 0), 1'b1,
                              mk_res(pbrq_pkg::ST_DONE, 0, 0, 1, 0)));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_INSERT, 31, 0, 0), 1'b1,
                              mk_res(pbrq_pkg::ST_NO_CHANGE, 0, 0, 1, 0)));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_PICK, 0, 0, 1), 1'b1,
                              mk_res(pbrq_pkg::ST_DONE, 31, 0, 0, 0)));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_SETPRIO, 0, 0, 0), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_INSERT, 0, 63, 1), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_SETPRIO, 7, 0, 0), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_INSERT, 7, 0, 0), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_INSERT, 1, 0, 0), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_INSERT, 2, 0, 0), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_INSERT, 3, 0, 0), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_REMOVE, 2, 0, 0), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_REMOVE, 3, 0, 0), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_PICK, 0, 0, 1), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_SETPRIO, 0, 10, 0), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_PICK, 0, 0, 0), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_SETPRIO, 7, 63, 0), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_REMOVE, 7, 0, 0), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_PICK, 31, 63, 1), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_REMOVE, 0, 0, 0), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_REMOVE, 1, 0, 0), 1'b0, blank));
    directed.push_back(mk_row(mk_cmd(pbrq_pkg::OP_PICK, 0, 0, 1), 1'b0, blank));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_with_gaps(directed[i].cmd, directed[i].typed, directed[i].res);
    for (int n = 0; n < RANDOM_WORDS; n++) send_with_gaps(random_cmd(), 1'b0, blank);
    in_chan.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d command words (%0d picks, %0d of them idle, %0d with no change),",
             words_sent, picks_seen, idle_picks, no_change_seen);
    $display("%0d result words checked, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("priority_bitmap_run_queue_unit_tb: clean");
    end else begin
      $display("priority_bitmap_run_queue_unit_tb: errors");
    end
    $finish;
  end

  // receiver: result check and stall pattern, with one long hold-off
  initial begin
    sched_result_t exp_res;
    int            cyc;
    int            hold;
    bit            did_hold;
    cyc = 0;
    hold = 0;
    did_hold = 0;
    results_seen = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected: status %0b next %0d idle %0b"
                   , $realtime, out_chan.status, out_chan.next_task, out_chan.next_is_idle);
        end else begin
          exp_res = pending_results.pop_front();
          if (out_chan.status !== exp_res.status || out_chan.next_task !== exp_res.next_task ||
              out_chan.next_is_idle !== exp_res.next_is_idle ||
              out_chan.resched_req !== exp_res.resched_req ||
              out_chan.queue_empty !== exp_res.queue_empty) begin
            errors++;
            $display("%0t: mismatch expected st %0b nt %0d idle %0b rs %0b em %0b", $realtime,
                     exp_res.status, exp_res.next_task, exp_res.next_is_idle,
                     exp_res.resched_req, exp_res.queue_empty);
            $display("%0t:          actual   st %0b nt %0d idle %0b rs %0b em %0b", $realtime,
                     out_chan.status, out_chan.next_task, out_chan.next_is_idle,
                     out_chan.resched_req, out_chan.queue_empty);
          end
        end
      end
      cyc++;
      // pick ready for the next edge
      if (hold > 0) begin
        hold--;
        out_chan.ready <= 1'b0;
      end else if (!did_hold && results_seen == HOLD_AT) begin
        did_hold = 1'b1;
        hold = HOLD_CYCLES;
        out_chan.ready <= 1'b0;
      end else begin
        case ((cyc / 50) % 4)
          0: out_chan.ready <= 1'b1;
          1: out_chan.ready <= 1'($urandom_range(0, 1));
          2: out_chan.ready <= (cyc % 7) >= 3;
          default: out_chan.ready <= $urandom_range(0, 7) != 0;
        endcase
      end
    end
  end

  // watchdog on cycles without any accepted word
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word accepted for %0d cycles", $realtime, STALL_LIMIT);
    $display("priority_bitmap_run_queue_unit_tb: errors");
    $finish;
  end

endmodule
